FILE: hw/rtl/doq_pkg.sv
// ============================================================================
// doq_pkg
// Shared widths, result codes and controller/datapath signal groups for the
// deadline ordered completion queue.
// ============================================================================
package doq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RUN_W       = 16;
    localparam int TIME_W      = 32;
    localparam int JOB_W       = 8;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_ACCEPT   = 2'd0;
    localparam kind_t KIND_COMPLETE = 2'd1;
    localparam kind_t KIND_REJECT   = 2'd2;
    localparam kind_t KIND_NONE     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic load;
        logic calc_sum;
        logic calc_cmp;
        logic do_insert;
        logic do_reject;
        logic do_pop;
        logic pop_last;
        logic emit_none;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic full;
        logic head_expired;
        logic second_expired;
        logic out_free;
    } stat_t;

endpackage

FILE: hw/rtl/doq_in_if.sv
// ============================================================================
// doq_in_if
// Input channel: insert or tick requests with valid/ready transfer.
// ============================================================================
interface doq_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [doq_pkg::RUN_W-1:0]    run_time;
    logic [doq_pkg::TIME_W-1:0]   now;

    modport source (output valid, output op, output run_time, output now, input ready);
    modport sink   (input valid, input op, input run_time, input now, output ready);
endinterface

FILE: hw/rtl/doq_out_if.sv
// ============================================================================
// doq_out_if
// Output channel: result items with valid/ready transfer.
// ============================================================================
interface doq_out_if;
    logic                         valid;
    logic                         ready;
    logic [doq_pkg::KIND_W-1:0]   kind;
    logic [doq_pkg::JOB_W-1:0]    job_id;
    logic [doq_pkg::TIME_W-1:0]   deadline;
    logic                         last;

    modport source (output valid, output kind, output job_id, output deadline, output last,
                    input ready);
    modport sink   (input valid, input kind, input job_id, input deadline, input last,
                    output ready);
endinterface

FILE: hw/rtl/doq_ctrl.sv
// ============================================================================
// doq_ctrl
// Sequencer for insert (sum, compare, write) and tick (pop per cycle while the output is free).
// ============================================================================
module doq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  doq_pkg::stat_t stat,
    output doq_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_INS  = 5'b01000,
        ST_POP  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [doq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      may_pop;

    assign in_ready = (state_reg == ST_IDLE);
    assign may_pop  = stat.head_expired
                    && (cnt_reg < doq_pkg::CNT_W'(doq_pkg::MAX_RESULTS));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = (stat.op == doq_pkg::OP_TICK) ? ST_POP : ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.calc_cmp = 1'b1;
                state_next   = ST_INS;
            end
            ST_INS:
            begin
                if (stat.out_free)
                begin
                    if (stat.full)
                    begin
                        cmd.do_reject = 1'b1;
                    end
                    else
                    begin
                        cmd.do_insert = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (stat.out_free)
                begin
                    if (may_pop)
                    begin
                        cmd.do_pop   = 1'b1;
                        cmd.pop_last = !(stat.second_expired
                            && (cnt_reg < doq_pkg::CNT_W'(doq_pkg::MAX_RESULTS - 1)));
                        cnt_next     = cnt_reg + doq_pkg::CNT_W'(1);
                        if (cmd.pop_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.emit_none = (cnt_reg == '0);
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/doq_dp.sv
// ============================================================================
// doq_dp
// Sorted entry row with per-entry compare, shift insert, head pop, and the
// result output register.
// ============================================================================
module doq_dp #(
    parameter int DEPTH = doq_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  doq_pkg::cmd_t               cmd,
    output doq_pkg::stat_t              stat,
    input  logic                        in_op,
    input  logic [doq_pkg::RUN_W-1:0]   in_run_time,
    input  logic [doq_pkg::TIME_W-1:0]  in_now,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [doq_pkg::KIND_W-1:0]  out_kind,
    output logic [doq_pkg::JOB_W-1:0]   out_job_id,
    output logic [doq_pkg::TIME_W-1:0]  out_deadline,
    output logic                        out_last
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [doq_pkg::RUN_W-1:0]  run_reg;
    logic [doq_pkg::TIME_W-1:0] now_reg;
    logic [doq_pkg::TIME_W-1:0] dl_reg;
    logic [DEPTH-1:0]           c_reg, c_next;
    logic [DEPTH-1:0]           c_prev;
    logic [doq_pkg::TIME_W-1:0] dl_arr_reg [DEPTH];
    logic [doq_pkg::JOB_W-1:0]  id_arr_reg [DEPTH];
    logic [OCC_W-1:0]           occ_reg;
    logic [doq_pkg::JOB_W-1:0]  next_job_reg;
    logic [doq_pkg::TIME_W:0]   sum;
    logic                       emit;

    logic                        out_valid_reg;
    logic [doq_pkg::KIND_W-1:0]  out_kind_reg;
    logic [doq_pkg::JOB_W-1:0]   out_job_reg;
    logic [doq_pkg::TIME_W-1:0]  out_dl_reg;
    logic                        out_last_reg;

    assign sum    = {1'b0, now_reg} + {{(doq_pkg::TIME_W + 1 - doq_pkg::RUN_W){1'b0}}, run_reg};
    assign c_prev = {c_reg[DEPTH-2:0], 1'b0};
    assign emit   = cmd.do_insert || cmd.do_reject || cmd.do_pop || cmd.emit_none;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                c_next[i] = (occ_reg > OCC_W'(i)) && (dl_arr_reg[i] > dl_reg);
            end
            else
            begin
                c_next[i] = (occ_reg > OCC_W'(i)) && (dl_arr_reg[i] >= dl_reg);
            end
        end
    end

    assign stat.op             = in_op;
    assign stat.full           = (occ_reg == OCC_W'(DEPTH));
    assign stat.head_expired   = (occ_reg != '0) && (dl_arr_reg[0] < now_reg);
    assign stat.second_expired = (occ_reg > OCC_W'(1)) && (dl_arr_reg[1] < now_reg);
    assign stat.out_free       = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            run_reg <= in_run_time;
            now_reg <= in_now;
        end
        if (cmd.calc_sum)
        begin
            dl_reg <= sum[doq_pkg::TIME_W] ? '1 : sum[doq_pkg::TIME_W-1:0];
        end
        if (cmd.calc_cmp)
        begin
            c_reg <= c_next;
        end
        if (cmd.do_insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (c_prev[i])
                begin
                    if (i > 0)
                    begin
                        dl_arr_reg[i] <= dl_arr_reg[i-1];
                        id_arr_reg[i] <= id_arr_reg[i-1];
                    end
                end
                else if (c_reg[i] || (occ_reg == OCC_W'(i)))
                begin
                    dl_arr_reg[i] <= dl_reg;
                    id_arr_reg[i] <= next_job_reg;
                end
            end
        end
        else if (cmd.do_pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                dl_arr_reg[i] <= dl_arr_reg[i+1];
                id_arr_reg[i] <= id_arr_reg[i+1];
            end
        end
        if (emit)
        begin
            if (cmd.do_insert)
            begin
                out_kind_reg <= doq_pkg::KIND_ACCEPT;
                out_job_reg  <= next_job_reg;
                out_dl_reg   <= dl_reg;
                out_last_reg <= 1'b1;
            end
            else if (cmd.do_pop)
            begin
                out_kind_reg <= doq_pkg::KIND_COMPLETE;
                out_job_reg  <= id_arr_reg[0];
                out_dl_reg   <= dl_arr_reg[0];
                out_last_reg <= cmd.pop_last;
            end
            else
            begin
                out_kind_reg <= cmd.do_reject ? doq_pkg::KIND_REJECT : doq_pkg::KIND_NONE;
                out_job_reg  <= '0;
                out_dl_reg   <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            next_job_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_insert)
            begin
                occ_reg      <= occ_reg + OCC_W'(1);
                next_job_reg <= next_job_reg + doq_pkg::JOB_W'(1);
            end
            else if (cmd.do_pop)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_job_id   = out_job_reg;
    assign out_deadline = out_dl_reg;
    assign out_last     = out_last_reg;

endmodule

FILE: hw/rtl/deadline_ordered_completion_queue_core.sv
// ============================================================================
// deadline_ordered_completion_queue_core
// Deadline sorted job queue: insert with saturating deadline, tick drains
// expired head entries in order.
// ============================================================================
// Insert: accept, deadline add, per-entry compare, shift write; the result
//   is registered in the output register at the shift write.
// Tick: one head pop per cycle while the output register is free.
// Reset clears occupancy, the next job id and the sequencer; entry storage
//   is not cleared.
// ============================================================================
module deadline_ordered_completion_queue_core #(
    parameter int DEPTH = doq_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    doq_in_if.sink    in_ch,
    doq_out_if.source out_ch
);

    doq_pkg::cmd_t  cmd;
    doq_pkg::stat_t stat;

    doq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    doq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (in_ch.op),
        .in_run_time  (in_ch.run_time),
        .in_now       (in_ch.now),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_kind     (out_ch.kind),
        .out_job_id   (out_ch.job_id),
        .out_deadline (out_ch.deadline),
        .out_last     (out_ch.last)
    );

endmodule

FILE: hw/rtl/doq_checker.sv
// ============================================================================
// doq_checker
// Port level checks on the completion queue, bound to the top level.
// ============================================================================
module doq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [doq_pkg::KIND_W-1:0]  out_kind,
    input logic [doq_pkg::JOB_W-1:0]   out_job_id,
    input logic [doq_pkg::TIME_W-1:0]  out_deadline,
    input logic                        out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_job_id) && $stable(out_deadline) && $stable(out_last))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in progress");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != doq_pkg::KIND_COMPLETE) |-> out_last)
        else $error("single result without last");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == doq_pkg::KIND_NONE || out_kind == doq_pkg::KIND_REJECT)
            |-> (out_job_id == '0) && (out_deadline == '0))
        else $error("reject or idle tick with nonzero fields");

endmodule

bind deadline_ordered_completion_queue_core doq_checker u_doq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_job_id   (out_ch.job_id),
    .out_deadline (out_ch.deadline),
    .out_last     (out_ch.last)
);
